// ===== rtl/fvnh_pkg.sv =====
// Package of the fractal value noise height block.
// Holds configuration types, register indexes, reset values and the reciprocal table.
// Depends on nothing.
package fvnh_pkg;

   localparam int MAX_OCTAVES_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int RECIP_BITS      = 21;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int NOCT_W          = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_FREQ  = 3'd0,
      CSR_NUM_OCT    = 3'd1,
      CSR_HT_SCALE   = 3'd2,
      CSR_HT_OFFSET  = 3'd3,
      CSR_MAX_HEIGHT = 3'd4
   } csr_idx_type;

   localparam logic [15:0] RST_BASE_FREQ  = 16'd655;
   localparam logic [3:0]  RST_NUM_OCT    = 4'd5;
   localparam logic [7:0]  RST_HT_SCALE   = 8'd20;
   localparam logic [7:0]  RST_HT_OFFSET  = 8'd10;
   localparam logic [7:0]  RST_MAX_HEIGHT = 8'd99;

   // Settings used by the final normalization and output stages.
   typedef struct packed {
      logic [NOCT_W-1:0] noct;
      logic [7:0]        scale;
      logic signed [7:0] offset;
      logic [7:0]        max_h;
   } cfg_type;

   // Rounded reciprocal of the weight sum 2^n - 1, scaled by 2^21, indexed by n - 1.
   function automatic logic [RECIP_BITS:0] recip_rom(input logic [3:0] k);
      logic [RECIP_BITS:0] r;
      unique case (k)
         4'd0:  r = 22'd2097152;
         4'd1:  r = 22'd699051;
         4'd2:  r = 22'd299593;
         4'd3:  r = 22'd139810;
         4'd4:  r = 22'd67650;
         4'd5:  r = 22'd33288;
         4'd6:  r = 22'd16513;
         4'd7:  r = 22'd8224;
         4'd8:  r = 22'd4104;
         4'd9:  r = 22'd2050;
         4'd10: r = 22'd1025;
         4'd11: r = 22'd512;
         4'd12: r = 22'd256;
         4'd13: r = 22'd128;
         4'd14: r = 22'd64;
         default: r = 22'd32;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/fvnh_octave.sv =====
// One octave of lattice value noise: split, corner hashing and bilinear blend.
// Ten register stages. Depends on fvnh_pkg.
module fvnh_octave #(
   parameter int FRAC_BITS = fvnh_pkg::FRAC_BITS_DEF,
   parameter int OCT       = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [32:0]          px,
   input  logic signed [32:0]          pz,
   output logic signed [FRAC_BITS+2:0] smp
);
   import fvnh_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int SW = F + 3;

   logic signed [47:0] qx, qz;
   logic [F-1:0]       fx_in, fz_in;

   assign qx = 48'(px) <<< OCT;
   assign qz = 48'(pz) <<< OCT;

   generate
      if (F >= 16) begin : g_up
         assign fx_in = F'(qx[15:0]) << (F - 16);
         assign fz_in = F'(qz[15:0]) << (F - 16);
      end else begin : g_dn
         assign fx_in = qx[15:16-F];
         assign fz_in = qz[15:16-F];
      end
   endgenerate

   logic [31:0] cx_ff, cz_ff;
   logic [31:0] n_ff [4];
   logic [31:0] n2_ff [4];
   logic [31:0] n3_ff [4];
   logic [31:0] t_ff [4];
   logic [31:0] n4_ff [4];
   logic [31:0] h_ff [4];
   logic signed [F+1:0] v_ff [4];
   logic [F-1:0] fx_ff [6];
   logic [F-1:0] fz_ff [8];
   logic signed [2*F+3:0] p0_ff, p1_ff;
   logic signed [F+1:0]   v0_ff, v2_ff;
   logic signed [SW-1:0]  r0_ff, r1_ff, r0d_ff;
   logic signed [2*F+4:0] pz_ff;
   logic signed [SW-1:0]  smp_ff;

   logic [31:0] n_in [4];
   logic signed [F+1:0] v_in [4];
   logic signed [F+2:0] d0, d1;
   logic signed [F+3:0] dz;
   logic signed [SW-1:0] r0_in, r1_in, smp_in;
   logic signed [2*F+3:0] p0s, p1s;
   logic signed [2*F+4:0] pzs;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [31:0] ix, iz, m;
         ix = cx_ff + 32'(k % 2);
         iz = cz_ff + 32'(k / 2);
         m = ix + iz * 32'd57;
         n_in[k] = (m << 13) ^ m;
         v_in[k] = $signed({2'b01, {F{1'b0}}}) - $signed({1'b0, h_ff[k][30:30-F]});
      end
      d0 = SW'(v_ff[1]) - SW'(v_ff[0]);
      d1 = SW'(v_ff[3]) - SW'(v_ff[2]);
      p0s = p0_ff >>> F;
      p1s = p1_ff >>> F;
      r0_in = SW'(v0_ff) + SW'(p0s);
      r1_in = SW'(v2_ff) + SW'(p1s);
      dz = (F+4)'(r1_ff) - (F+4)'(r0_ff);
      pzs = pz_ff >>> F;
      smp_in = r0d_ff + SW'(pzs);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= qx[47:16];
         cz_ff <= qz[47:16];
         fx_ff[0] <= fx_in;
         fz_ff[0] <= fz_in;
         for (int j = 1; j < 6; j++) fx_ff[j] <= fx_ff[j-1];
         for (int j = 1; j < 8; j++) fz_ff[j] <= fz_ff[j-1];
         for (int k = 0; k < 4; k++) begin
            n_ff[k]  <= n_in[k];
            n2_ff[k] <= n_ff[k] * n_ff[k];
            n3_ff[k] <= n_ff[k];
            t_ff[k]  <= n2_ff[k] * 32'd15731 + 32'd789221;
            n4_ff[k] <= n3_ff[k];
            h_ff[k]  <= n4_ff[k] * t_ff[k] + 32'd1376312589;
            v_ff[k]  <= v_in[k];
         end
         p0_ff  <= d0 * $signed({1'b0, fx_ff[5]});
         p1_ff  <= d1 * $signed({1'b0, fx_ff[5]});
         v0_ff  <= v_ff[0];
         v2_ff  <= v_ff[2];
         r0_ff  <= r0_in;
         r1_ff  <= r1_in;
         pz_ff  <= dz * $signed({1'b0, fz_ff[7]});
         r0d_ff <= r0_ff;
         smp_ff <= smp_in;
      end
   end

   assign smp = smp_ff;

endmodule

// ===== rtl/fvnh_norm.sv =====
// Weighted octave sum, normalization, scaling, rounding and clamping.
// Six register stages. Depends on fvnh_pkg.
module fvnh_norm #(
   parameter int MAX_OCTAVES = fvnh_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = fvnh_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        en,
   input  fvnh_pkg::cfg_type           cfg,
   input  logic signed [FRAC_BITS+2:0] smp [MAX_OCTAVES],
   output logic [7:0]                  height
);
   import fvnh_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int SW = F + 3;
   localparam int TW = SW + MAX_OCTAVES;
   localparam int PW = TW + RECIP_BITS + 2;
   localparam int NW = F + 4;
   localparam int HW = NW + 10;
   localparam int RW = HW - F;

   logic signed [TW-1:0] tot_ff, tot_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [NW-1:0] norm_ff;
   logic signed [NW+8:0] hs_ff;
   logic signed [RW-1:0] rnd_ff;
   logic                 neg_ff;
   logic [7:0]           out_ff;
   logic signed [PW-1:0] prod_r;
   logic signed [HW-1:0] h_c;

   always_comb begin
      tot_in = '0;
      for (int i = 0; i < MAX_OCTAVES; i++) begin
         if (NOCT_W'(i) < cfg.noct) begin
            tot_in = tot_in + (TW'(smp[i]) <<< (cfg.noct - NOCT_W'(i) - NOCT_W'(1)));
         end
      end
      prod_r = (prod_ff + (PW'(1) <<< (RECIP_BITS - 1))) >>> RECIP_BITS;
      h_c = HW'(hs_ff) + (HW'(cfg.offset) <<< F);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tot_ff  <= tot_in;
         prod_ff <= PW'(tot_ff) * $signed({1'b0, recip_rom(4'(cfg.noct - NOCT_W'(1)))});
         norm_ff <= NW'(prod_r);
         hs_ff   <= norm_ff * $signed({1'b0, cfg.scale});
         neg_ff  <= h_c[HW-1];
         rnd_ff  <= RW'((h_c + (HW'(1) <<< (F - 1))) >>> F);
         if (neg_ff) begin
            out_ff <= 8'd0;
         end else if (rnd_ff > $signed({1'b0, RW'(cfg.max_h)})) begin
            out_ff <= cfg.max_h;
         end else begin
            out_ff <= rnd_ff[7:0];
         end
      end
   end

   assign height = out_ff;

endmodule

// ===== rtl/fractal_value_noise_height.sv =====
// Top level of the fractal value noise height block.
// Holds the settings registers, the coordinate scaling stage, the octave units and the
// output stages. Depends on fvnh_pkg, fvnh_octave and fvnh_norm.
//
// Usage: each req_ transaction carries one column (req_world_x, req_world_z); each
// produces exactly one rsp_ transaction carrying the terrain height, in order.
// The datapath is a single stalling pipeline of 17 register stages: one for the
// coordinate times base frequency products, ten in every octave unit (split, corner
// hash, three hash multiplies, value, two blend multiplies and two blend adds) and six
// for the weighted sum, reciprocal multiply, scaling, rounding and clamping. Every
// octave has its own unit, so one transaction is accepted per cycle unless the pipeline
// is frozen.
// When the receiver holds rsp_ready low with a result waiting, the whole pipeline
// freezes and req_ready drops; no transaction is lost or repeated, and input is still
// taken while a result waits as long as the receiver keeps taking results.
// Reset clears the pipeline valid bits and loads the default settings. Settings are
// written through csr_we / csr_index / csr_data; the user must change them only while
// the pipeline is empty, which the block does not enforce. Unknown indexes are ignored.
module fractal_value_noise_height #(
   parameter int MAX_OCTAVES = fvnh_pkg::MAX_OCTAVES_DEF,
   parameter int FRAC_BITS   = fvnh_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_world_x,
   input  logic signed [15:0]                  req_world_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_height,
   input  logic                                csr_we,
   input  logic [fvnh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvnh_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fvnh_pkg::*;

   localparam int LAT = 17;
   localparam int SW  = FRAC_BITS + 3;

   logic [15:0]       bf_ff;
   logic [3:0]        noct_ff;
   logic [7:0]        scale_ff;
   logic signed [7:0] offs_ff;
   logic [7:0]        maxh_ff;
   logic [LAT-1:0]    vld_ff;
   logic signed [32:0] px_ff, pz_ff;
   logic              en;
   cfg_type           cfg;
   logic signed [SW-1:0] smp [MAX_OCTAVES];

   // The pipeline advances unless a finished result is held by the receiver.
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   // Octave count is forced into one through the number of octave units.
   always_comb begin
      cfg.scale  = scale_ff;
      cfg.offset = offs_ff;
      cfg.max_h  = maxh_ff;
      if (noct_ff == 4'd0) begin
         cfg.noct = NOCT_W'(1);
      end else if (NOCT_W'(noct_ff) > NOCT_W'(MAX_OCTAVES)) begin
         cfg.noct = NOCT_W'(MAX_OCTAVES);
      end else begin
         cfg.noct = NOCT_W'(noct_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_ff    <= RST_BASE_FREQ;
         noct_ff  <= RST_NUM_OCT;
         scale_ff <= RST_HT_SCALE;
         offs_ff  <= RST_HT_OFFSET;
         maxh_ff  <= RST_MAX_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_FREQ:  bf_ff    <= csr_data;
            CSR_NUM_OCT:    noct_ff  <= csr_data[3:0];
            CSR_HT_SCALE:   scale_ff <= csr_data[7:0];
            CSR_HT_OFFSET:  offs_ff  <= csr_data[7:0];
            CSR_MAX_HEIGHT: maxh_ff  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Stage one: exact scaled coordinates, 16 fractional bits.
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_world_x * $signed({1'b0, bf_ff});
         pz_ff <= req_world_z * $signed({1'b0, bf_ff});
      end
   end

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      fvnh_octave #(
         .FRAC_BITS (FRAC_BITS),
         .OCT       (i)
      ) u_oct (
         .clock (clock),
         .en    (en),
         .px    (px_ff),
         .pz    (pz_ff),
         .smp   (smp[i])
      );
   end

   fvnh_norm #(
      .MAX_OCTAVES (MAX_OCTAVES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_norm (
      .clock  (clock),
      .en     (en),
      .cfg    (cfg),
      .smp    (smp),
      .height (rsp_height)
   );

endmodule
